[sv/utf8_to_utf16_transcoder_macros.svh]
// assertion macros for the utf8 to utf16 transcoder
// no dependencies; included by the top level only
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define U8U16_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8u16 assertion failed");
// next-cycle implication, checked outside reset
`define U8U16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8u16 assertion failed");
`else
`define U8U16_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define U8U16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/u8u16_pkg.sv]
// shared types, constants and helper functions of the utf8 to utf16 transcoder
// no dependencies
`timescale 1ns / 1ps

package u8u16_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] unit_t;
  typedef logic [2:0]  seq_len_t;
  typedef logic [1:0]  cnt_t;

  localparam int HELD_DEPTH = 3;
  localparam int MAX_UNITS  = 3;

  localparam unit_t       UNIT_REPL    = 16'hFFFD;
  localparam unit_t       SURR_HI_BASE = 16'hD800;
  localparam unit_t       SURR_LO_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] LOW10_MASK   = 21'h003FF;

  localparam byte_t LEAD4_MASK = 8'hF8;
  localparam byte_t LEAD4_CODE = 8'hF0;
  localparam byte_t LEAD3_MASK = 8'hF0;
  localparam byte_t LEAD3_CODE = 8'hE0;
  localparam byte_t LEAD2_MASK = 8'hE0;
  localparam byte_t LEAD2_CODE = 8'hC0;
  localparam byte_t PAY4_MASK  = 8'h07;
  localparam byte_t PAY2_MASK  = 8'h1F;

  // result of decoding one byte together with the held bytes
  typedef struct packed {
    cnt_t                     n;
    unit_t [MAX_UNITS-1:0]    units;
    logic                     flush;
    seq_len_t                 need;
  } dec_res_t;

  // group of units handed to the output buffer
  typedef struct packed {
    cnt_t                     n;
    unit_t [MAX_UNITS-1:0]    units;
    logic                     text_end;
  } obuf_load_t;

  // sequence length from a lead byte, zero for an invalid lead
  function automatic seq_len_t lead_length(input byte_t b);
    seq_len_t len;
    if (!b[7])                              len = 3'd1;
    else if ((b & LEAD2_MASK) == LEAD2_CODE) len = 3'd2;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) len = 3'd3;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) len = 3'd4;
    else                                     len = 3'd0;
    return len;
  endfunction

  // two byte sequence to a code unit
  function automatic unit_t cp2(input byte_t b0, input byte_t b1);
    byte_t p0;
    p0 = b0 & PAY2_MASK;
    return {5'd0, p0[4:0], b1[5:0]};
  endfunction

  // single byte after a replaced lead: ascii passes, anything else is replaced
  function automatic unit_t lone_unit(input byte_t b);
    return (lead_length(b) == 3'd1) ? {8'd0, b} : UNIT_REPL;
  endfunction

endpackage

[sv/u8u16_if.sv]
// valid/ready channel interfaces for byte input and code unit output
// depends on u8u16_pkg
`timescale 1ns / 1ps

interface u8u16_in_if import u8u16_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  text_end;

  modport source (output valid, output data_byte, output text_end, input ready);
  modport sink   (input valid, input data_byte, input text_end, output ready);
endinterface

interface u8u16_out_if import u8u16_pkg::*; ();
  logic  valid;
  logic  ready;
  unit_t code_unit;
  logic  run_last;
  logic  final_unit;

  modport source (output valid, output code_unit, output run_last, output final_unit,
                  input ready);
  modport sink   (input valid, input code_unit, input run_last, input final_unit,
                  output ready);
endinterface

[sv/utf8_to_utf16_transcoder.sv]
// utf8 to utf16 transcoder: byte register, sequence state, decoder, output buffer
// path: each byte is registered, then its units are loaded into the output buffer when that is free
// throughput: one byte per cycle while each byte gives at most one unit and out_chan is ready;
//   a byte that gives several units holds the output buffer until all are sent (one unit per transfer)
// reset: synchronous active-low rst_n empties both registers and closes any sequence
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_macros.svh"

module utf8_to_utf16_transcoder import u8u16_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  u8u16_in_if.sink     in_chan,
  u8u16_out_if.source  out_chan
);

  // input register
  logic   in_vld_r;
  byte_t  in_byte_r;
  logic   in_end_r;

  // open sequence state; held bytes are only read below the held count
  byte_t [HELD_DEPTH-1:0] held_r;
  cnt_t                   held_cnt_r;
  seq_len_t               seq_len_r;

  dec_res_t    dec;
  obuf_load_t  obuf_in;
  logic        obuf_load;
  logic        obuf_free;
  logic        take;
  logic        in_xfer;

  // a byte leaves the input register once its units have room, or right
  // away when it only extends the open sequence
  assign take          = in_vld_r && (obuf_free || (dec.n == 2'd0));
  assign in_chan.ready = !in_vld_r || take;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (take) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_chan.data_byte;
      in_end_r  <= in_chan.text_end;
    end
  end

  u8u16_dec u_dec (
    .held_bytes (held_r),
    .held_count (held_cnt_r),
    .seq_len    (seq_len_r),
    .data_byte  (in_byte_r),
    .text_end   (in_end_r),
    .res        (dec)
  );

  // sequence bookkeeping: close on flush, else append the byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      seq_len_r  <= 3'd0;
    end else if (take) begin
      if (dec.flush) begin
        held_cnt_r <= 2'd0;
        seq_len_r  <= 3'd0;
      end else begin
        held_cnt_r <= held_cnt_r + 2'd1;
        seq_len_r  <= dec.need;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !dec.flush) begin
      held_r[held_cnt_r] <= in_byte_r;
    end
  end

  // hand the decoded group to the output side
  assign obuf_load        = take && (dec.n != 2'd0);
  assign obuf_in.n        = dec.n;
  assign obuf_in.units    = dec.units;
  assign obuf_in.text_end = in_end_r;

  u8u16_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (obuf_load),
    .load_data (obuf_in),
    .free      (obuf_free),
    .out_ch    (out_chan)
  );

  // an open sequence always holds at least its lead, and never all of it
  `U8U16_ASSERT_IMPL(a_open_iff_held, clk, rst_n, 1'b1, ((seq_len_r == 3'd0) == (held_cnt_r == 2'd0)))
  `U8U16_ASSERT_IMPL(a_held_below_len, clk, rst_n, seq_len_r != 3'd0, {1'b0, held_cnt_r} < seq_len_r)
  // a flushing byte leaves no sequence open
  `U8U16_ASSERT_NEXT(a_flush_closes, clk, rst_n, take && dec.flush, held_cnt_r == 2'd0)
  // a group never lands on units still waiting in the output buffer
  `U8U16_ASSERT_IMPL(a_load_when_free, clk, rst_n, obuf_load, obuf_free)

endmodule

[sv/u8u16_dec.sv]
// combinational decoder: one byte plus the held bytes to up to three code units
// depends on u8u16_pkg
`timescale 1ns / 1ps

module u8u16_dec import u8u16_pkg::*; (
  input  byte_t [HELD_DEPTH-1:0] held_bytes,
  input  cnt_t                   held_count,
  input  seq_len_t               seq_len,
  input  byte_t                  data_byte,
  input  logic                   text_end,
  output dec_res_t               res
);

  byte_t [3:0]  win;
  seq_len_t     total;
  seq_len_t     len_in;
  seq_len_t     len0;
  seq_len_t     len1;
  logic [20:0]  cp4;
  logic [20:0]  c4;
  logic [20:0]  c4_lo;

  always_comb begin
    for (int k = 0; k < HELD_DEPTH; k++) begin
      win[k] = (k < int'(held_count)) ? held_bytes[k] : data_byte;
    end
    win[3] = data_byte;
  end

  assign total  = {1'b0, held_count} + 3'd1;
  assign len_in = lead_length(data_byte);
  assign len0   = lead_length(win[0]);
  assign len1   = lead_length(win[1]);
  assign cp4    = {win[0][2:0] & PAY4_MASK[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
  assign c4     = cp4 - SUPP_BASE;
  assign c4_lo  = c4 & LOW10_MASK;

  always_comb begin
    res.need  = (seq_len != 3'd0) ? seq_len : ((len_in == 3'd0) ? 3'd1 : len_in);
    res.flush = (total >= res.need) || text_end;
    res.n     = 2'd0;
    res.units = '0;
    if (res.flush) begin
      if (len0 != 3'd0 && len0 == total) begin
        // complete sequence
        res.n = 2'd1;
        unique case (len0)
          3'd1: res.units[0] = {8'd0, win[0]};
          3'd2: res.units[0] = cp2(win[0], win[1]);
          3'd3: res.units[0] = {win[0][3:0], win[1][5:0], win[2][5:0]};
          3'd4: begin
            if (cp4[20:16] != 5'd0) begin
              res.n        = 2'd2;
              res.units[0] = SURR_HI_BASE + {5'd0, c4[20:10]};
              res.units[1] = SURR_LO_BASE + c4_lo[15:0];
            end else begin
              res.units[0] = cp4[15:0];
            end
          end
          default: res.units[0] = UNIT_REPL;
        endcase
      end else begin
        // lead replaced, bytes after it decoded as the end of the text
        res.units[0] = UNIT_REPL;
        case (held_count)
          2'd0: res.n = 2'd1;
          2'd1: begin
            res.n        = 2'd2;
            res.units[1] = lone_unit(win[1]);
          end
          default: begin
            if (len1 == 3'd2) begin
              res.n        = 2'd2;
              res.units[1] = cp2(win[1], win[2]);
            end else begin
              res.n        = 2'd3;
              res.units[1] = lone_unit(win[1]);
              res.units[2] = lone_unit(win[2]);
            end
          end
        endcase
      end
    end
  end

endmodule

[sv/u8u16_obuf.sv]
// output buffer: holds the units of one byte and sends them one per transfer
// depends on u8u16_pkg and u8u16_out_if
`timescale 1ns / 1ps

module u8u16_obuf import u8u16_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  obuf_load_t         load_data,
  output logic               free,
  u8u16_out_if.source        out_ch
);

  unit_t [MAX_UNITS-1:0] units_r;
  cnt_t                  cnt_r;
  cnt_t                  idx_r;
  logic                  end_r;
  logic                  last;
  logic                  xfer;

  assign last = (idx_r == (cnt_r - 2'd1));
  assign xfer = out_ch.valid && out_ch.ready;
  assign free = (cnt_r == 2'd0) || (xfer && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= load_data.n;
      idx_r <= 2'd0;
    end else if (xfer) begin
      if (last) begin
        cnt_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      units_r <= load_data.units;
      end_r   <= load_data.text_end;
    end
  end

  always_comb begin
    case (idx_r)
      2'd0:    out_ch.code_unit = units_r[0];
      2'd1:    out_ch.code_unit = units_r[1];
      default: out_ch.code_unit = units_r[2];
    endcase
  end

  assign out_ch.valid      = (cnt_r != 2'd0);
  assign out_ch.run_last   = last;
  assign out_ch.final_unit = last && end_r;

endmodule
